// ===== sv/lztbc_pkg.sv =====
// package for the lz token bit cost estimator
// holds codes, command and status structs and the Q12 cost rom; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lztbc_pkg;

  localparam int ADAPT_SHIFT = 4;
  localparam int LIT_BITS    = 8;
  localparam int PROB_W      = 8;
  localparam int PRICE_W     = 16;
  localparam int COST_W      = 20;
  localparam int OFFSET_W    = 12;
  localparam int BYTE_W      = 8;

  localparam logic [PROB_W-1:0] PROB_RESET = 8'd110;

  localparam logic FUNC_LITERAL = 1'b0;
  localparam logic FUNC_MATCH   = 1'b1;

  localparam logic [1:0] TREE_LEN = 2'd0;
  localparam logic [1:0] TREE_LIT = 2'd1;
  localparam logic [1:0] TREE_OFF = 2'd2;

  typedef struct packed {
    logic load;
    logic issue;
    logic len_last;
    logic clear;
    logic out_load;
  } lztbc_cmd_t;

  typedef struct packed {
    logic func;
    logic clear_last;
  } lztbc_sts_t;

  typedef logic [PRICE_W-1:0] cost_rom_t [256];

  // round(-log2(p/256) * 4096), evaluated at elaboration only
  function automatic cost_rom_t build_cost_rom();
    cost_rom_t    rom;
    logic [127:0] prod;
    logic [63:0]  m;
    logic [63:0]  frac;
    logic [63:0]  val;
    int           e;
    rom[0] = '0;
    for (int p = 1; p < 256; p++) begin
      e = 0;
      while ((p >> (e + 1)) != 0) e++;
      m = 64'(p) << (62 - e);
      frac = '0;
      for (int k = 0; k < 40; k++) begin
        prod = {64'd0, m} * {64'd0, m};
        m = prod[125:62];
        frac = frac << 1;
        if (m[63]) begin
          frac = frac | 64'd1;
          m = m >> 1;
        end
      end
      val = ((64'(8 - e) << 40) - frac + (64'd1 << 27)) >> 28;
      rom[p] = val[PRICE_W-1:0];
    end
    return rom;
  endfunction

  localparam cost_rom_t COST_ROM = build_cost_rom();

endpackage

`default_nettype wire

// ===== sv/lztbc_in_if.sv =====
// token input channel: valid/ready handshake with the token payload
// depends on lztbc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lztbc_in_if;
  import lztbc_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [BYTE_W-1:0]   literal_byte;
  logic [BYTE_W-1:0]   match_length;
  logic [OFFSET_W-1:0] match_offset;

  modport source (output valid, func, literal_byte, match_length, match_offset,
                  input ready);
  modport sink   (input valid, func, literal_byte, match_length, match_offset,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/lztbc_out_if.sv =====
// result output channel: valid/ready handshake with cost and coded offset
// depends on lztbc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lztbc_out_if;
  import lztbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   bit_cost;
  logic [OFFSET_W-1:0] coded_offset;

  modport source (output valid, bit_cost, coded_offset, input ready);
  modport sink   (input valid, bit_cost, coded_offset, output ready);
endinterface

`default_nettype wire

// ===== sv/lztbc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lztbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lztbc_ctrl.sv =====
// controller: clear pass, token acceptance, node walk sequencing, output handshake
// depends on lztbc_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lztbc_ctrl #(
  parameter int LEN_BITS  = 8,
  parameter int DIST_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  tok_valid,
  output      logic                  tok_ready,
  output      logic                  res_valid,
  input  wire logic                  res_ready,
  output      lztbc_pkg::lztbc_cmd_t cmd,
  input  wire lztbc_pkg::lztbc_sts_t sts
);
  import lztbc_pkg::*;

  localparam int STEP_W = $clog2(LEN_BITS + DIST_BITS + 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [STEP_W-1:0] total;
  logic              out_valid, out_valid_next;

  assign total = (sts.func == FUNC_MATCH) ? STEP_W'(LEN_BITS + DIST_BITS)
                                          : STEP_W'(LEN_BITS + LIT_BITS);

  assign tok_ready = (state == ST_IDLE);
  assign res_valid = out_valid;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tok_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // the last node executes in the cycle where step reaches total
        if (step < total) begin
          cmd.issue    = 1'b1;
          cmd.len_last = (step == STEP_W'(LEN_BITS - 1));
          step_next    = step + STEP_W'(1);
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (res_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lztbc_datapath.sv =====
// datapath: token registers, repeat offset, probability rams, node price and adapt
// depends on lztbc_pkg and lztbc_ram
`timescale 1ns / 1ps
`default_nettype none

module lztbc_datapath #(
  parameter int LEN_BITS  = 8,
  parameter int DIST_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lztbc_pkg::lztbc_cmd_t           cmd,
  output      lztbc_pkg::lztbc_sts_t           sts,
  input  wire logic                            func,
  input  wire logic [lztbc_pkg::BYTE_W-1:0]    literal_byte,
  input  wire logic [lztbc_pkg::BYTE_W-1:0]    match_length,
  input  wire logic [lztbc_pkg::OFFSET_W-1:0]  match_offset,
  output      logic [lztbc_pkg::COST_W-1:0]    bit_cost,
  output      logic [lztbc_pkg::OFFSET_W-1:0]  coded_offset
);
  import lztbc_pkg::*;

  // token state
  logic                 tok_func;
  logic [OFFSET_W-1:0]  coded;
  logic [OFFSET_W-1:0]  prev_offset;
  logic [LEN_BITS-1:0]  len_sr;
  logic [DIST_BITS-1:0] sec_sr;
  logic [DIST_BITS-1:0] rd_node;
  logic                 in_len;
  logic [COST_W-1:0]    acc;
  logic [DIST_BITS-1:0] clr_addr;

  // execute stage
  logic                 ex_valid;
  logic [1:0]           ex_tree;
  logic                 ex_bit;
  logic [DIST_BITS-1:0] ex_addr;

  logic [OFFSET_W-1:0]  coded_in;
  logic                 issue_bit;

  logic [PROB_W-1:0]    len_rdata, lit_rdata, off_rdata;
  logic [PROB_W-1:0]    p, p_new;
  logic [8:0]           p_inv;
  logic [8:0]           up_step, up_sum;
  logic [PROB_W-1:0]    dn_step;
  logic [PROB_W-1:0]    rom_idx;
  logic [PRICE_W-1:0]   price;

  logic                 len_we, lit_we, off_we;
  logic [PROB_W-1:0]    wdata;
  logic [DIST_BITS-1:0] waddr;

  assign sts.func       = tok_func;
  assign sts.clear_last = &clr_addr;

  assign coded_in  = (func == FUNC_LITERAL) ? OFFSET_W'(literal_byte)
                   : (match_offset == prev_offset) ? '0 : match_offset;
  assign issue_bit = in_len ? len_sr[LEN_BITS-1] : sec_sr[DIST_BITS-1];

  always_comb begin
    case (ex_tree)
      TREE_LEN: p = len_rdata;
      TREE_LIT: p = lit_rdata;
      TREE_OFF: p = off_rdata;
      default:  p = off_rdata;
    endcase
  end

  // node price uses the probability before adaptation
  always_comb begin
    p_inv   = 9'd256 - {1'b0, p};
    rom_idx = ex_bit ? p : p_inv[7:0];
    price   = COST_ROM[rom_idx];
    up_step = p_inv >> ADAPT_SHIFT;
    if (up_step == 9'd0) up_step = 9'd1;
    up_sum  = {1'b0, p} + up_step;
    dn_step = p >> ADAPT_SHIFT;
    if (dn_step == '0) dn_step = 8'd1;
    if (ex_bit) begin
      p_new = (up_sum > 9'd255) ? 8'd255 : up_sum[7:0];
    end else begin
      p_new = (dn_step >= p) ? 8'd1 : p - dn_step;
    end
  end

  // clear pass presets every entry; narrower stores see their addresses repeat
  assign len_we = cmd.clear || (ex_valid && ex_tree == TREE_LEN);
  assign lit_we = cmd.clear || (ex_valid && ex_tree == TREE_LIT);
  assign off_we = cmd.clear || (ex_valid && ex_tree == TREE_OFF);
  assign wdata  = cmd.clear ? PROB_RESET : p_new;
  assign waddr  = cmd.clear ? clr_addr : ex_addr;

  lztbc_ram #(.WIDTH(PROB_W), .DEPTH(2 ** LEN_BITS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (waddr[LEN_BITS-1:0]),
    .wdata (wdata),
    .raddr (rd_node[LEN_BITS-1:0]),
    .rdata (len_rdata)
  );

  lztbc_ram #(.WIDTH(PROB_W), .DEPTH(2 ** LIT_BITS)) u_lit_ram (
    .clk   (clk),
    .we    (lit_we),
    .waddr (waddr[LIT_BITS-1:0]),
    .wdata (wdata),
    .raddr (rd_node[LIT_BITS-1:0]),
    .rdata (lit_rdata)
  );

  lztbc_ram #(.WIDTH(PROB_W), .DEPTH(2 ** DIST_BITS)) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_node),
    .rdata (off_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_offset <= '0;
      clr_addr    <= '0;
      ex_valid    <= 1'b0;
      tok_func    <= FUNC_LITERAL;
      in_len      <= 1'b1;
    end else begin
      ex_valid <= cmd.issue;
      if (cmd.clear) begin
        clr_addr <= clr_addr + DIST_BITS'(1);
      end
      if (cmd.load) begin
        tok_func <= func;
        in_len   <= 1'b1;
        if (func == FUNC_MATCH) begin
          prev_offset <= match_offset;
        end
      end else if (cmd.issue && cmd.len_last) begin
        in_len <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coded   <= coded_in;
      rd_node <= DIST_BITS'(1);
      acc     <= '0;
      len_sr  <= (func == FUNC_MATCH) ? LEN_BITS'(match_length) : '0;
      sec_sr  <= (func == FUNC_MATCH) ? DIST_BITS'(coded_in)
                                      : DIST_BITS'(literal_byte) << (DIST_BITS - LIT_BITS);
    end else begin
      if (cmd.issue) begin
        ex_bit  <= issue_bit;
        ex_addr <= rd_node;
        ex_tree <= in_len ? TREE_LEN : (tok_func == FUNC_MATCH) ? TREE_OFF : TREE_LIT;
        rd_node <= cmd.len_last ? DIST_BITS'(1) : {rd_node[DIST_BITS-2:0], issue_bit};
        if (in_len) begin
          len_sr <= len_sr << 1;
        end else begin
          sec_sr <= sec_sr << 1;
        end
      end
      if (ex_valid) begin
        acc <= acc + COST_W'(price);
      end
    end
    if (cmd.out_load) begin
      bit_cost     <= acc;
      coded_offset <= coded;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lz_token_bit_cost_estimator.sv =====
// lz token bit cost estimator, top level
// Tokens enter on the token channel (valid/ready); a transaction carries func,
// literal_byte, match_length and match_offset. Each token gives exactly one
// transaction on the result channel with bit_cost (Q12 bits) and coded_offset.
// Tokens are processed one at a time. After acceptance the sequencer walks
// LEN_BITS length-tree nodes and then 8 literal or DIST_BITS offset nodes, one
// node per cycle, with the ram read of the next node overlapping the
// read-modify-write of the current one. The next token is taken only after
// the walk ends and its result is loaded into the output register. After
// reset a clearing pass presets all probability rams to 110; no token is
// taken meanwhile. The result sits in an output register; if the receiver
// stalls, the next token is still accepted and walked, and its result waits
// until the register frees up.
// depends on lztbc_pkg, lztbc_in_if, lztbc_out_if, lztbc_ctrl, lztbc_datapath
`timescale 1ns / 1ps
`default_nettype none

module lz_token_bit_cost_estimator #(
  parameter int LEN_BITS  = 8,
  parameter int DIST_BITS = 12
) (
  input wire logic clk,
  input wire logic rst,
  lztbc_in_if.sink   token,
  lztbc_out_if.source result
);
  import lztbc_pkg::*;

  lztbc_cmd_t cmd;
  lztbc_sts_t sts;

  lztbc_ctrl #(.LEN_BITS(LEN_BITS), .DIST_BITS(DIST_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (token.valid),
    .tok_ready (token.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lztbc_datapath #(.LEN_BITS(LEN_BITS), .DIST_BITS(DIST_BITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (token.func),
    .literal_byte (token.literal_byte),
    .match_length (token.match_length),
    .match_offset (token.match_offset),
    .bit_cost     (result.bit_cost),
    .coded_offset (result.coded_offset)
  );

endmodule

`default_nettype wire

// ===== tb/lz_token_bit_cost_estimator_tb.sv =====
`timescale 1ns / 1ps
// testbench for lz_token_bit_cost_estimator: a short table of directed tokens,
// then shaped random tokens, each result checked against a local bit-tree price model
// depends on lztbc_pkg, lztbc_in_if, lztbc_out_if and the rtl top level

module lz_token_bit_cost_estimator_tb;
  import lztbc_pkg::*;

  localparam int LEN_NODES     = 8;
  localparam int LIT_NODES     = 8;
  localparam int OFF_NODES     = 12;
  localparam int PROB_SHIFT    = 4;
  localparam int PROB_INIT     = 110;
  localparam int RANDOM_TOKENS = 1800;
  localparam int DRAIN_CYCLES  = 64;
  localparam int MAX_SHOWN     = 10;

  typedef enum logic [1:0] {LEN_TREE, LIT_TREE, OFF_TREE} tree_e;

  typedef struct packed {
    logic                func;
    logic [BYTE_W-1:0]   lit;
    logic [BYTE_W-1:0]   len;
    logic [OFFSET_W-1:0] off;
  } token_t;

  typedef struct packed {
    logic [COST_W-1:0]   cost;
    logic [OFFSET_W-1:0] coded;
  } estimate_t;

  typedef struct {
    token_t    tok;
    bit        has_cost;
    bit        has_coded;
    estimate_t want;
  } directed_row_t;

  logic clk;
  logic rst;

  lztbc_in_if  tok_if ();
  lztbc_out_if res_if ();

  lz_token_bit_cost_estimator #(
    .LEN_BITS  (LEN_NODES),
    .DIST_BITS (OFF_NODES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .token  (tok_if),
    .result (res_if)
  );

  // price model state
  int unsigned         q12_cost [256];
  logic [7:0]          len_prob [1 << LEN_NODES];
  logic [7:0]          lit_prob [1 << LIT_NODES];
  logic [7:0]          off_prob [1 << OFF_NODES];
  logic [OFFSET_W-1:0] last_offset;

  estimate_t     pending [$];
  directed_row_t directed [$];

  int n_sent     = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_literals = 0;
  int n_matches  = 0;
  int n_zero_off = 0;
  bit calm       = 1'b0;

  // random token shaping state
  int     burst_left   = 0;
  bit     burst_flip   = 1'b0;
  token_t burst_a;
  token_t burst_b;
  logic [OFFSET_W-1:0] gen_last_off = '0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("timeout: %0d of %0d results seen", n_checked, n_sent);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void reset_price_model();
    q12_cost[0] = 0;
    for (int p = 1; p < 256; p++)
      q12_cost[p] = int'($floor(-$ln(p / 256.0) / $ln(2.0) * 4096.0 + 0.5));
    foreach (len_prob[i]) len_prob[i] = 8'(PROB_INIT);
    foreach (lit_prob[i]) lit_prob[i] = 8'(PROB_INIT);
    foreach (off_prob[i]) off_prob[i] = 8'(PROB_INIT);
    last_offset = '0;
  endfunction

  function automatic logic [7:0] adapt(input logic [7:0] p, input logic b);
    int unsigned q;
    int unsigned s;
    q = p;
    if (b) begin
      s = (256 - q) >> PROB_SHIFT;
      if (s == 0) s = 1;
      q = (q + s > 255) ? 255 : q + s;
    end else begin
      s = q >> PROB_SHIFT;
      if (s == 0) s = 1;
      q = (s >= q) ? 1 : q - s;
    end
    return q[7:0];
  endfunction

  // msb-first walk from node 1, pricing each bit with the probability before adapting
  function automatic int unsigned walk_tree(input tree_e tree, input int unsigned value,
                                            input int nbits);
    int unsigned total;
    int unsigned node;
    logic        b;
    logic [7:0]  p;
    total = 0;
    node = 1;
    for (int i = nbits - 1; i >= 0; i--) begin
      b = ((value >> i) & 1) != 0;
      case (tree)
        LEN_TREE: p = len_prob[node];
        LIT_TREE: p = lit_prob[node];
        default:  p = off_prob[node];
      endcase
      total += b ? q12_cost[p] : q12_cost[256 - p];
      p = adapt(p, b);
      case (tree)
        LEN_TREE: len_prob[node] = p;
        LIT_TREE: lit_prob[node] = p;
        default:  off_prob[node] = p;
      endcase
      node = 2 * node + b;
    end
    return total;
  endfunction

  function automatic estimate_t estimate_token(input token_t t);
    int unsigned         total;
    logic [OFFSET_W-1:0] coded;
    if (t.func == FUNC_LITERAL) begin
      total = walk_tree(LEN_TREE, 0, LEN_NODES);
      total += walk_tree(LIT_TREE, t.lit, LIT_NODES);
      coded = OFFSET_W'(t.lit);
    end else begin
      total = walk_tree(LEN_TREE, t.len, LEN_NODES);
      coded = (t.off == last_offset) ? '0 : t.off;
      last_offset = t.off;
      total += walk_tree(OFF_TREE, coded, OFF_NODES);
    end
    return '{cost: COST_W'(total), coded: coded};
  endfunction

  function automatic void add_row(input logic func, input int lit, input int len, input int off,
                                  input bit has_cost, input int unsigned cost,
                                  input bit has_coded, input int coded);
    directed_row_t r;
    r.tok = '{func: func, lit: BYTE_W'(lit), len: BYTE_W'(len), off: OFFSET_W'(off)};
    r.has_cost = has_cost;
    r.has_coded = has_coded;
    r.want = '{cost: COST_W'(cost), coded: OFFSET_W'(coded)};
    directed.insert(directed.size(), r);
  endfunction

  function automatic void load_directed();
    // fresh trees: sixteen zero bits, each at the reset probability
    add_row(FUNC_LITERAL, 8'h00, 8'hff, 12'hfff, 1, 16 * q12_cost[256 - PROB_INIT], 1, 8'h00);
    add_row(FUNC_LITERAL, 8'hff, 8'h00, 12'h000, 0, 0, 1, 8'hff);
    // zero offset equals the previous offset after reset
    add_row(FUNC_MATCH, 8'h00, 8'd0, 12'd0, 0, 0, 1, 0);
    add_row(FUNC_MATCH, 8'hff, 8'd255, 12'd4095, 0, 0, 1, 4095);
    add_row(FUNC_MATCH, 8'h00, 8'd255, 12'd4095, 0, 0, 1, 0);
    add_row(FUNC_MATCH, 8'h00, 8'd1, 12'd1, 0, 0, 1, 1);
    add_row(FUNC_MATCH, 8'hff, 8'd1, 12'd1, 0, 0, 1, 0);
    add_row(FUNC_MATCH, 8'h00, 8'd128, 12'd2048, 0, 0, 1, 2048);
    add_row(FUNC_MATCH, 8'h00, 8'd127, 12'd2047, 0, 0, 1, 2047);
    // literal in between keeps the previous offset
    add_row(FUNC_LITERAL, 8'h80, 8'd5, 12'd2047, 0, 0, 1, 8'h80);
    add_row(FUNC_MATCH, 8'h00, 8'd3, 12'd2047, 0, 0, 1, 0);
    add_row(FUNC_LITERAL, 8'h7f, 8'hff, 12'hfff, 0, 0, 1, 8'h7f);
    add_row(FUNC_LITERAL, 8'h55, 8'haa, 12'haaa, 0, 0, 1, 8'h55);
    add_row(FUNC_LITERAL, 8'haa, 8'h55, 12'h555, 0, 0, 1, 8'haa);
    // zero offset that is not a repeat still codes as zero
    add_row(FUNC_MATCH, 8'h00, 8'd0, 12'd0, 0, 0, 1, 0);
    add_row(FUNC_MATCH, 8'h00, 8'haa, 12'd0, 0, 0, 1, 0);
    add_row(FUNC_MATCH, 8'h00, 8'h55, 12'h555, 0, 0, 1, 12'h555);
    add_row(FUNC_MATCH, 8'h00, 8'haa, 12'haaa, 0, 0, 1, 12'haaa);
    add_row(FUNC_MATCH, 8'h00, 8'haa, 12'h555, 0, 0, 1, 12'h555);
    add_row(FUNC_LITERAL, 8'h12, 8'hff, 12'h555, 0, 0, 1, 8'h12);
    add_row(FUNC_MATCH, 8'h00, 8'hff, 12'h555, 0, 0, 1, 0);
  endfunction

  function automatic token_t fresh_token();
    token_t t;
    int     pick;
    t.func = ($urandom_range(99) < 45) ? FUNC_LITERAL : FUNC_MATCH;
    t.lit = BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 5)       t.len = '0;
    else if (pick < 35) t.len = BYTE_W'($urandom_range(16, 1));
    else                t.len = BYTE_W'($urandom_range(255, 1));
    pick = $urandom_range(99);
    if (pick < 30)      t.off = gen_last_off;
    else if (pick < 35) t.off = '0;
    else if (pick < 50) t.off = OFFSET_W'($urandom_range(15, 1));
    else                t.off = OFFSET_W'($urandom_range(4095, 1));
    return t;
  endfunction

  // mostly independent tokens; now and then a burst of one token, or two in
  // alternation, to push node probabilities to their limits
  function automatic token_t random_token();
    token_t t;
    if (burst_left > 0) begin
      burst_left--;
      burst_flip = !burst_flip;
      t = burst_flip ? burst_b : burst_a;
    end else begin
      t = fresh_token();
      if ($urandom_range(99) < 4) begin
        burst_left = $urandom_range(60, 20);
        burst_flip = 1'b0;
        burst_a = t;
        burst_b = $urandom_range(1) ? t : fresh_token();
      end
    end
    if (t.func == FUNC_MATCH) gen_last_off = t.off;
    return t;
  endfunction

  task automatic send_token(input token_t t);
    while (!calm && $urandom_range(99) < 18) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid        <= 1'b1;
    tok_if.func         <= t.func;
    tok_if.literal_byte <= t.lit;
    tok_if.match_length <= t.len;
    tok_if.match_offset <= t.off;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_all_results();
    tok_if.valid <= 1'b0;
    do @(posedge clk); while (n_checked < n_sent);
  endtask

  task automatic report_error(input string what);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("[%0t] error: %s", $realtime, what);
  endtask

  initial begin
    reset_price_model();
    load_directed();
    rst                 <= 1'b1;
    tok_if.valid        <= 1'b0;
    tok_if.func         <= FUNC_LITERAL;
    tok_if.literal_byte <= '0;
    tok_if.match_length <= '0;
    tok_if.match_offset <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_token(directed[i].tok);
    wait_all_results();
    for (int i = 0; i < RANDOM_TOKENS; i++) begin
      calm = (i >= 700 && i < 1000);
      if (i == 1200) wait_all_results();
      send_token(random_token());
    end
    calm = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending.size() != 0) report_error($sformatf("%0d results never arrived", pending.size()));
    $display("checked %0d tokens: %0d literals, %0d matches (%0d coded with offset zero)",
             n_checked, n_literals, n_matches, n_zero_off);
    $display("%0d directed rows, %0d random tokens, %0d errors",
             directed.size(), RANDOM_TOKENS, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin : monitor
    estimate_t want;
    estimate_t got;
    if (!rst) begin
      if (tok_if.valid && tok_if.ready) begin
        want = estimate_token('{func: tok_if.func, lit: tok_if.literal_byte,
                                len: tok_if.match_length, off: tok_if.match_offset});
        if (tok_if.func == FUNC_LITERAL) begin
          n_literals++;
        end else begin
          n_matches++;
          if (want.coded == '0) n_zero_off++;
        end
        // typed values from the table take the place of the model's
        if (n_taken < directed.size()) begin
          if (directed[n_taken].has_cost) want.cost = directed[n_taken].want.cost;
          if (directed[n_taken].has_coded) want.coded = directed[n_taken].want.coded;
        end
        n_taken++;
        pending.insert(pending.size(), want);
      end
      if (res_if.valid && res_if.ready) begin
        n_checked++;
        got = '{cost: res_if.bit_cost, coded: res_if.coded_offset};
        if (pending.size() == 0) begin
          report_error($sformatf("unexpected result: bit_cost %0d coded_offset %0d",
                                 got.cost, got.coded));
        end else begin
          want = pending.pop_front();
          if (got.cost !== want.cost || got.coded !== want.coded)
            report_error($sformatf(
              "result %0d: bit_cost exp %0d got %0d, coded_offset exp %0d got %0d",
              n_checked, want.cost, got.cost, want.coded, got.coded));
        end
      end
    end
  end

endmodule

// ===== sim.f =====
sv/lztbc_pkg.sv
sv/lztbc_in_if.sv
sv/lztbc_out_if.sv
sv/lztbc_ram.sv
sv/lztbc_ctrl.sv
sv/lztbc_datapath.sv
sv/lz_token_bit_cost_estimator.sv
tb/lz_token_bit_cost_estimator_tb.sv
